@@ hdl/utcd_pkg.sv @@
// utcd_pkg: shared constants, stage item types and the month table for the
// UTC date to epoch seconds pipeline. No dependencies.

package utcd_pkg;

   // calendar constants
   localparam int unsigned YearBase    = 1900;
   localparam int unsigned EpochDayNum = 719528;  // day number of 1970-01-01
   localparam int unsigned DaysPerYear = 365;
   localparam int unsigned SecsPerDay  = 86400;
   localparam int unsigned SecsPerHour = 3600;
   localparam int unsigned SecsPerMin  = 60;
   localparam int unsigned MonthsPerYr = 12;
   localparam int unsigned YearsPerCen = 100;

   // reciprocal for month / 12, exact over 0..255
   localparam int unsigned Div12Mul   = 171;
   localparam int unsigned Div12Shift = 11;

   // reciprocal for year / 100, exact over 0..4095
   localparam int unsigned Div100Mul   = 5243;
   localparam int unsigned Div100Shift = 19;

   // field widths
   localparam int unsigned YearsW  = 10;
   localparam int unsigned MonthW  = 8;
   localparam int unsigned DayW    = 5;
   localparam int unsigned HourW   = 5;
   localparam int unsigned MinW    = 6;
   localparam int unsigned SecW    = 6;
   localparam int unsigned EpSecW  = 36;
   localparam int unsigned EpDayW  = 20;

   // internal widths
   localparam int unsigned YoffW   = 11;  // years since 1900 plus carried years
   localparam int unsigned YearW   = 12;  // full year, up to 2944
   localparam int unsigned CentW   = 5;   // year / 100 - 19 fits, full value up to 29
   localparam int unsigned MonW    = 4;   // month 0..11
   localparam int unsigned HmsW    = 17;  // hour, minute and second in seconds
   localparam int unsigned DaySumW = 22;  // signed working width of the day sum

   // after the month split
   typedef struct packed {
      logic [YoffW-1:0]  yoff;
      logic [MonW-1:0]   month;
      logic [DayW-1:0]   day;
      logic [HourW-1:0]  hour;
      logic [MinW-1:0]   minute;
      logic [SecW-1:0]   second;
   } split_type;

   // after the century counts
   typedef struct packed {
      logic [YearW-1:0]  year;
      logic [CentW-1:0]  cent_prev;   // (year - 1) / 100
      logic [CentW-1:0]  cent;        // year / 100
      logic [MonW-1:0]   month;
      logic [DayW-1:0]   day;
      logic [HmsW-1:0]   hms;
   } year_type;

   // after the day sum
   typedef struct packed {
      logic signed [EpDayW-1:0] days;
      logic [HmsW-1:0]          hms;
   } days_type;

   // days before the first of each month in a common year
   function automatic logic [8:0] month_start(input logic [MonW-1:0] m);
      logic [8:0] r;
      case (m)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         4'd11:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/utc_date_to_epoch_seconds.sv @@
// Converts a broken-down UTC calendar time (years since 1900, zero-based
// month, day, hour, minute, second) into signed days and seconds since
// 1970-01-01 under proleptic Gregorian rules. A month index of 12 or more
// carries into the year; no field is range checked and out-of-range values
// add linearly. One item is taken every clock cycle while req_stall is low;
// each result shows on the rsp outputs after passing the four register stages
// (month split, century counts, day sum, seconds scaling). rsp_stall holds a
// stage only while it and every stage after it hold an item, and reaches
// req_stall in the same cycle when all four are full; empty stages keep
// filling while the output is stalled.
// Depends on utcd_pkg, utcd_split, utcd_year, utcd_days and utcd_secs.

module utc_date_to_epoch_seconds (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [utcd_pkg::YearsW-1:0]         req_years_since_1900,
   input  logic [utcd_pkg::MonthW-1:0]         req_month_index,
   input  logic [utcd_pkg::DayW-1:0]           req_day_of_month,
   input  logic [utcd_pkg::HourW-1:0]          req_hour_of_day,
   input  logic [utcd_pkg::MinW-1:0]           req_minute_of_hour,
   input  logic [utcd_pkg::SecW-1:0]           req_second_of_minute,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [utcd_pkg::EpSecW-1:0]  rsp_epoch_seconds,
   output logic signed [utcd_pkg::EpDayW-1:0]  rsp_epoch_days
);

   logic                 split_valid;
   logic                 split_stall;
   utcd_pkg::split_type  split_item;
   logic                 year_valid;
   logic                 year_stall;
   utcd_pkg::year_type   year_item;
   logic                 days_valid;
   logic                 days_stall;
   utcd_pkg::days_type   days_item;

   // month split
   utcd_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_years  (req_years_since_1900),
      .in_month  (req_month_index),
      .in_day    (req_day_of_month),
      .in_hour   (req_hour_of_day),
      .in_minute (req_minute_of_hour),
      .in_second (req_second_of_minute),
      .out_valid (split_valid),
      .out_stall (split_stall),
      .out_item  (split_item)
   );

   // full year and century counts
   utcd_year u_year (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_stall  (split_stall),
      .in_item   (split_item),
      .out_valid (year_valid),
      .out_stall (year_stall),
      .out_item  (year_item)
   );

   // day count since the epoch
   utcd_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (year_valid),
      .in_stall  (year_stall),
      .in_item   (year_item),
      .out_valid (days_valid),
      .out_stall (days_stall),
      .out_item  (days_item)
   );

   // seconds and result register
   utcd_secs u_secs (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (days_valid),
      .in_stall    (days_stall),
      .in_item     (days_item),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_seconds (rsp_epoch_seconds),
      .out_days    (rsp_epoch_days)
   );

endmodule

@@ hdl/utcd_split.sv @@
// utcd_split: first pipeline stage, splits the month index into carried
// years and month of year. Depends on utcd_pkg.

module utcd_split (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic [utcd_pkg::YearsW-1:0]   in_years,
   input  logic [utcd_pkg::MonthW-1:0]   in_month,
   input  logic [utcd_pkg::DayW-1:0]     in_day,
   input  logic [utcd_pkg::HourW-1:0]    in_hour,
   input  logic [utcd_pkg::MinW-1:0]     in_minute,
   input  logic [utcd_pkg::SecW-1:0]     in_second,
   output logic                          out_valid,
   input  logic                          out_stall,
   output utcd_pkg::split_type           out_item
);

   logic                 valid_ff;
   utcd_pkg::split_type  item_ff;
   utcd_pkg::split_type  item_in;
   logic [15:0]          quot_prod;
   logic [4:0]           quot;
   logic [7:0]           rem;

   // month / 12 by reciprocal, remainder by subtraction
   always_comb begin
      quot_prod      = 16'(in_month) * 16'(utcd_pkg::Div12Mul);
      quot           = quot_prod[15:11];
      rem            = in_month - 8'(quot) * 8'(utcd_pkg::MonthsPerYr);
      item_in.yoff   = utcd_pkg::YoffW'(in_years) + utcd_pkg::YoffW'(quot);
      item_in.month  = rem[utcd_pkg::MonW-1:0];
      item_in.day    = in_day;
      item_in.hour   = in_hour;
      item_in.minute = in_minute;
      item_in.second = in_second;
   end

   // stage holds while its item waits downstream
   assign in_stall  = valid_ff & out_stall;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hdl/utcd_year.sv @@
// utcd_year: second pipeline stage, forms the full year, the century counts
// and the time of day in seconds. Depends on utcd_pkg.

module utcd_year (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  utcd_pkg::split_type  in_item,
   output logic                 out_valid,
   input  logic                 out_stall,
   output utcd_pkg::year_type   out_item
);

   logic                            valid_ff;
   utcd_pkg::year_type              item_ff;
   utcd_pkg::year_type              item_in;
   logic [utcd_pkg::YearW-1:0]      year;
   logic [utcd_pkg::YearW-1:0]      year_prev;
   logic [24:0]                     cent_prod;
   logic [24:0]                     cent_prev_prod;

   // year / 100 and (year - 1) / 100 by reciprocal
   always_comb begin
      year           = utcd_pkg::YearW'(in_item.yoff) + utcd_pkg::YearW'(utcd_pkg::YearBase);
      year_prev      = year - utcd_pkg::YearW'(1);
      cent_prod      = 25'(year) * 25'(utcd_pkg::Div100Mul);
      cent_prev_prod = 25'(year_prev) * 25'(utcd_pkg::Div100Mul);
      item_in.year      = year;
      item_in.cent      = cent_prod[23:19];
      item_in.cent_prev = cent_prev_prod[23:19];
      item_in.month     = in_item.month;
      item_in.day       = in_item.day;
      item_in.hms       = utcd_pkg::HmsW'(in_item.hour) * utcd_pkg::HmsW'(utcd_pkg::SecsPerHour)
                        + utcd_pkg::HmsW'(in_item.minute) * utcd_pkg::HmsW'(utcd_pkg::SecsPerMin)
                        + utcd_pkg::HmsW'(in_item.second);
   end

   assign in_stall  = valid_ff & out_stall;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hdl/utcd_days.sv @@
// utcd_days: third pipeline stage, leap test and signed day count since the
// epoch. Depends on utcd_pkg.

module utcd_days (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  utcd_pkg::year_type  in_item,
   output logic                out_valid,
   input  logic                out_stall,
   output utcd_pkg::days_type  out_item
);

   logic                                valid_ff;
   utcd_pkg::days_type                  item_ff;
   utcd_pkg::days_type                  item_in;
   logic [utcd_pkg::YearW-1:0]          year_prev;
   logic [utcd_pkg::YearW-1:0]          cent_years;
   logic                                leap;
   logic                                leap_add;
   logic signed [utcd_pkg::DaySumW-1:0] day_sum;

   always_comb begin
      year_prev  = in_item.year - utcd_pkg::YearW'(1);
      cent_years = utcd_pkg::YearW'(in_item.cent) * utcd_pkg::YearW'(utcd_pkg::YearsPerCen);
      // divisible by 4, and not a century unless divisible by 400
      leap       = (in_item.year[1:0] == 2'b00)
                 && ((cent_years != in_item.year) || (in_item.cent[1:0] == 2'b00));
      leap_add   = leap && (in_item.month >= utcd_pkg::MonW'(2));
      // day number of the date minus that of the epoch
      day_sum = $signed(utcd_pkg::DaySumW'(in_item.year) *
                        utcd_pkg::DaySumW'(utcd_pkg::DaysPerYear))
              + $signed(utcd_pkg::DaySumW'(year_prev[utcd_pkg::YearW-1:2]))
              - $signed(utcd_pkg::DaySumW'(in_item.cent_prev))
              + $signed(utcd_pkg::DaySumW'(in_item.cent_prev[utcd_pkg::CentW-1:2]))
              + $signed(utcd_pkg::DaySumW'(utcd_pkg::month_start(in_item.month)))
              + $signed(utcd_pkg::DaySumW'(in_item.day))
              + $signed(utcd_pkg::DaySumW'(leap_add))
              - $signed(utcd_pkg::DaySumW'(utcd_pkg::EpochDayNum));
      item_in.days = day_sum[utcd_pkg::EpDayW-1:0];
      item_in.hms  = in_item.hms;
   end

   assign in_stall  = valid_ff & out_stall;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hdl/utcd_secs.sv @@
// utcd_secs: last pipeline stage, scales days to seconds and adds the time
// of day; this is the result register. Depends on utcd_pkg.

module utcd_secs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  utcd_pkg::days_type                  in_item,
   output logic                                out_valid,
   input  logic                                out_stall,
   output logic signed [utcd_pkg::EpSecW-1:0]  out_seconds,
   output logic signed [utcd_pkg::EpDayW-1:0]  out_days
);

   localparam int unsigned ProdW = utcd_pkg::EpSecW + 2;

   logic                               valid_ff;
   logic signed [utcd_pkg::EpSecW-1:0] secs_ff;
   logic signed [utcd_pkg::EpDayW-1:0] days_ff;
   logic signed [utcd_pkg::EpSecW-1:0] secs_in;
   logic signed [ProdW-1:0]            days_ext;
   logic signed [ProdW-1:0]            secs_full;

   // days * 86400 + time of day
   always_comb begin
      days_ext  = ProdW'(in_item.days);
      secs_full = days_ext * $signed(ProdW'(utcd_pkg::SecsPerDay))
                + $signed(ProdW'(in_item.hms));
      secs_in   = secs_full[utcd_pkg::EpSecW-1:0];
   end

   assign in_stall    = valid_ff & out_stall;
   assign out_valid   = valid_ff;
   assign out_seconds = secs_ff;
   assign out_days    = days_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         secs_ff <= secs_in;
         days_ff <= in_item.days;
      end
   end

endmodule

@@ tb/sv/utcd_epoch_checker.sv @@
`timescale 1ns / 100ps
// utcd_epoch_checker: watches both channels of the UTC date to epoch seconds
// converter, predicts each result from its accepted item and compares in order.
// Depends on utcd_pkg for the field widths and calendar constants.

module utcd_epoch_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [utcd_pkg::YearsW-1:0]         req_years_since_1900,
   input  logic [utcd_pkg::MonthW-1:0]         req_month_index,
   input  logic [utcd_pkg::DayW-1:0]           req_day_of_month,
   input  logic [utcd_pkg::HourW-1:0]          req_hour_of_day,
   input  logic [utcd_pkg::MinW-1:0]           req_minute_of_hour,
   input  logic [utcd_pkg::SecW-1:0]           req_second_of_minute,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [utcd_pkg::EpSecW-1:0]  rsp_epoch_seconds,
   input  logic signed [utcd_pkg::EpDayW-1:0]  rsp_epoch_days,
   output int                                  mismatch_count,
   output int                                  outstanding
);

   typedef struct packed {
      logic signed [utcd_pkg::EpSecW-1:0] seconds;
      logic signed [utcd_pkg::EpDayW-1:0] days;
   } epoch_type;

   // days ahead of each month in a common year, index 0 is january
   localparam logic [11:0][8:0] LeadDays = {
      9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
      9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
   };

   epoch_type epoch_due_q[$];
   int        fails = 0;

   // gregorian day number of a date, month already folded into 0..11
   function automatic longint day_number(input longint y, input int m, input longint d);
      longint n;
      n = 365 * y + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400
          + longint'(LeadDays[m]) + d;
      // leap day counts once february is past
      if (m >= 2 && (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0)) begin
         n = n + 1;
      end
      return n;
   endfunction

   function automatic epoch_type predict_epoch(
      input logic [utcd_pkg::YearsW-1:0] yrs,
      input logic [utcd_pkg::MonthW-1:0] mon,
      input logic [utcd_pkg::DayW-1:0]   day,
      input logic [utcd_pkg::HourW-1:0]  hr,
      input logic [utcd_pkg::MinW-1:0]   mi,
      input logic [utcd_pkg::SecW-1:0]   se
   );
      epoch_type r;
      longint    year;
      longint    days;
      longint    secs;
      // whole years carried out of the month index
      year = longint'(utcd_pkg::YearBase) + longint'(yrs)
             + longint'(mon) / utcd_pkg::MonthsPerYr;
      days = day_number(year, int'(mon) % utcd_pkg::MonthsPerYr, longint'(day))
             - day_number(1970, 0, 1);
      secs = ((days * 24 + longint'(hr)) * 60 + longint'(mi)) * 60 + longint'(se);
      r.seconds = secs[utcd_pkg::EpSecW-1:0];
      r.days    = days[utcd_pkg::EpDayW-1:0];
      return r;
   endfunction

   // compare the result leaving, then record the item entering
   always @(posedge clock) begin : watch
      epoch_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (epoch_due_q.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("%0t: result with none due, seconds %0d days %0d",
                           $time, rsp_epoch_seconds, rsp_epoch_days);
               end
            end else begin
               want = epoch_due_q.pop_front();
               if (rsp_epoch_seconds !== want.seconds || rsp_epoch_days !== want.days) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%0t: seconds exp %0d got %0d, days exp %0d got %0d",
                              $time, $signed(want.seconds), rsp_epoch_seconds,
                              $signed(want.days), rsp_epoch_days);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            epoch_due_q.push_back(predict_epoch(req_years_since_1900, req_month_index,
                                                req_day_of_month, req_hour_of_day,
                                                req_minute_of_hour, req_second_of_minute));
         end
      end
      mismatch_count <= fails;
      outstanding    <= epoch_due_q.size();
   end

endmodule

@@ tb/sv/utc_date_to_epoch_seconds_tb.sv @@
`timescale 1ns / 100ps
// utc_date_to_epoch_seconds_tb: drives dated items into the converter with
// random pacing on both sides and reports the verdict of the epoch checker.
// Depends on utcd_pkg, utc_date_to_epoch_seconds and utcd_epoch_checker.

module utc_date_to_epoch_seconds_tb;

   localparam int RandomItems = 790;
   localparam int CalmTail    = 90;
   localparam int LongHold    = 150;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [utcd_pkg::YearsW-1:0]         req_years_since_1900;
   logic [utcd_pkg::MonthW-1:0]         req_month_index;
   logic [utcd_pkg::DayW-1:0]           req_day_of_month;
   logic [utcd_pkg::HourW-1:0]          req_hour_of_day;
   logic [utcd_pkg::MinW-1:0]           req_minute_of_hour;
   logic [utcd_pkg::SecW-1:0]           req_second_of_minute;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic signed [utcd_pkg::EpSecW-1:0]  rsp_epoch_seconds;
   logic signed [utcd_pkg::EpDayW-1:0]  rsp_epoch_days;

   int mismatch_count;
   int outstanding;

   // pacing controls for the sender and the receiver
   bit hold_asked  = 1'b0;
   bit calm        = 1'b0;
   int tx_gap_pct  = 20;
   int rx_idle_pct = 10;

   utc_date_to_epoch_seconds dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_years_since_1900 (req_years_since_1900),
      .req_month_index      (req_month_index),
      .req_day_of_month     (req_day_of_month),
      .req_hour_of_day      (req_hour_of_day),
      .req_minute_of_hour   (req_minute_of_hour),
      .req_second_of_minute (req_second_of_minute),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_epoch_seconds    (rsp_epoch_seconds),
      .rsp_epoch_days       (rsp_epoch_days)
   );

   utcd_epoch_checker epoch_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_years_since_1900 (req_years_since_1900),
      .req_month_index      (req_month_index),
      .req_day_of_month     (req_day_of_month),
      .req_hour_of_day      (req_hour_of_day),
      .req_minute_of_hour   (req_minute_of_hour),
      .req_second_of_minute (req_second_of_minute),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_epoch_seconds    (rsp_epoch_seconds),
      .rsp_epoch_days       (rsp_epoch_days),
      .mismatch_count       (mismatch_count),
      .outstanding          (outstanding)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one item after an optional idle burst, return once it is taken
   task automatic send_date(input int yrs, input int mon, input int day,
                            input int hr, input int mi, input int se);
      int gap;
      if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_years_since_1900 <= yrs[utcd_pkg::YearsW-1:0];
      req_month_index      <= mon[utcd_pkg::MonthW-1:0];
      req_day_of_month     <= day[utcd_pkg::DayW-1:0];
      req_hour_of_day      <= hr[utcd_pkg::HourW-1:0];
      req_minute_of_hour   <= mi[utcd_pkg::MinW-1:0];
      req_second_of_minute <= se[utcd_pkg::SecW-1:0];
      do @(posedge clock); while (req_stall);
   endtask

   // mostly calendar-shaped times, the rest any bit pattern
   task automatic send_random_date();
      if ($urandom_range(0, 9) < 3) begin
         send_date($urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
         send_date($urandom_range(0, 1023),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(12, 255)
                                               : $urandom_range(0, 11),
                   $urandom_range(1, 31), $urandom_range(0, 23),
                   $urandom_range(0, 59), $urandom_range(0, 60));
      end
   endtask

   // receiver pacing: random stall bursts, one long hold when asked
   initial begin : rx_pacing
      int burst;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_asked) begin
            rsp_stall <= 1'b1;
            repeat (LongHold) @(posedge clock);
            hold_asked = 1'b0;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
            burst = $urandom_range(1, 17);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int n;
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_years_since_1900 <= '0;
      req_month_index      <= '0;
      req_day_of_month     <= '0;
      req_hour_of_day      <= '0;
      req_minute_of_hour   <= '0;
      req_second_of_minute <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // epoch itself, all zero fields, earliest and latest times
      send_date(70, 0, 1, 0, 0, 0);
      send_date(0, 0, 0, 0, 0, 0);
      send_date(0, 0, 1, 0, 0, 0);
      send_date(1023, 255, 31, 31, 63, 63);
      // leap second and the 2038 rollover of a 32-bit count
      send_date(116, 11, 31, 23, 59, 60);
      send_date(138, 0, 19, 3, 14, 8);
      // leap day rules: 400 years, 100 years, 4 years, plain years
      send_date(100, 1, 29, 12, 0, 0);
      send_date(100, 2, 1, 0, 0, 0);
      send_date(0, 2, 1, 0, 0, 0);
      send_date(200, 2, 1, 0, 0, 0);
      send_date(500, 2, 1, 0, 0, 0);
      send_date(104, 2, 1, 0, 0, 0);
      send_date(101, 2, 1, 0, 0, 0);
      send_date(900, 1, 29, 0, 0, 0);
      // month index carrying into the year
      send_date(70, 12, 1, 0, 0, 0);
      send_date(70, 23, 31, 0, 0, 0);
      send_date(70, 24, 1, 0, 0, 0);
      send_date(0, 255, 1, 0, 0, 0);
      // day past month end, day zero, hour minute second past range, last year
      send_date(70, 1, 31, 0, 0, 0);
      send_date(70, 2, 0, 0, 0, 0);
      send_date(70, 0, 1, 31, 63, 63);
      send_date(1023, 0, 31, 23, 59, 59);

      // long receiver hold while items keep coming back to back
      hold_asked = 1'b1;
      tx_gap_pct = 0;
      repeat (40) send_random_date();

      for (n = 0; n < RandomItems; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: tx_gap_pct = 0;
               1: tx_gap_pct = 10;
               default: tx_gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
               0: rx_idle_pct = 0;
               1: rx_idle_pct = 8;
               default: rx_idle_pct = 25;
            endcase
         end
         if (n == RandomItems - CalmTail) begin
            calm = 1'b1;
         end
         send_random_date();
      end
      req_valid <= 1'b0;

      // drain, then keep watching for anything stray
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
